>>> rtl/core/evst_pkg.sv
// shared types and constants of the echo-verified serial transmitter
package evst_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TICK_W  = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd10;

  // configuration register index
  localparam logic REG_ECHO_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ECHO    = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_CONSUME = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_FAULT    = 3'd2,
    ST_TOO_LONG = 3'd3,
    ST_STORED   = 3'd4
  } status_t;

endpackage

>>> rtl/core/evst_ram.sv
// generic single-write, single-read ram with registered read data
module evst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/evst_cfg.sv
// apb register file holding the echo timeout
module evst_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [evst_pkg::TICK_W-1:0] echo_timeout
);

  logic [evst_pkg::TICK_W-1:0] timeout_r;
  logic [evst_pkg::TICK_W-1:0] timeout_nxt;
  logic                        sel_timeout;

  assign pready      = 1'b1;
  assign sel_timeout = (paddr[2] == evst_pkg::REG_ECHO_TIMEOUT);

  // write beat on the access phase
  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && pready && sel_timeout) begin
      timeout_nxt = pwdata[evst_pkg::TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= evst_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // read back
  assign prdata = sel_timeout ? {{(32-evst_pkg::TICK_W){1'b0}}, timeout_r} : 32'd0;
  assign echo_timeout = timeout_r;

endmodule

>>> rtl/core/evst_core.sv
// input register, frame state update and result register
module evst_core #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  input  logic [evst_pkg::TICK_W-1:0] echo_timeout,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic                        out_tx_valid,
  output logic [7:0]                  out_tx_byte,
  output logic                        out_busy_flag,
  output logic                        out_fault_flag,
  output logic                        out_drop_seen
);

  localparam int unsigned AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

  // input register
  logic       v_r;
  logic [1:0] act_r;
  logic [7:0] data_r;
  logic       last_r;

  // frame state
  logic [CW-1:0]               load_count_r, load_count_nxt;
  logic                        load_ovf_r, load_ovf_nxt;
  logic [CW-1:0]               frame_size_r, frame_size_nxt;
  logic [CW-1:0]               send_pos_r, send_pos_nxt;
  logic [7:0]                  expected_r, expected_nxt;
  logic                        awaiting_r, awaiting_nxt;
  logic                        sending_r, sending_nxt;
  logic                        faulted_r, faulted_nxt;
  logic                        drop_r, drop_nxt;
  logic [evst_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic [7:0]                  first_byte_r, first_byte_nxt;

  // store access and read bypass
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_q;
  logic          byp_hit_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    next_byte;
  logic [CW:0]   pos_inc;
  logic [CW:0]   rd_pos;

  // result
  logic [2:0] status_c;
  logic       txv_c;
  logic [7:0] txb_c;
  logic       seen_c;
  logic [CW:0] cnt_inc;
  logic        ovf_c;

  logic       out_valid_r;
  logic [2:0] status_r;
  logic       txv_r;
  logic [7:0] txb_r;
  logic       busy_r;
  logic       fault_r;
  logic       seen_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_r  <= in_action;
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  // prefetched byte at send position plus one
  assign next_byte = byp_hit_r ? byp_data_r : mem_q;
  assign pos_inc   = {1'b0, send_pos_r} + {{CW{1'b0}}, 1'b1};
  assign cnt_inc   = {1'b0, load_count_r} + {{CW{1'b0}}, 1'b1};

  // per-beat state update
  always_comb begin
    load_count_nxt = load_count_r;
    load_ovf_nxt   = load_ovf_r;
    frame_size_nxt = frame_size_r;
    send_pos_nxt   = send_pos_r;
    expected_nxt   = expected_r;
    awaiting_nxt   = awaiting_r;
    sending_nxt    = sending_r;
    faulted_nxt    = faulted_r;
    drop_nxt       = drop_r;
    ticks_nxt      = ticks_r;
    first_byte_nxt = first_byte_r;
    mem_we         = 1'b0;
    mem_waddr      = load_count_r[AW-1:0];
    status_c       = evst_pkg::ST_OK;
    txv_c          = 1'b0;
    txb_c          = 8'd0;
    seen_c         = 1'b0;
    ovf_c          = load_ovf_r;

    if (v_r) begin
      unique case (evst_pkg::action_t'(act_r))
        evst_pkg::ACT_LOAD: begin
          if (faulted_r) begin
            status_c       = evst_pkg::ST_FAULT;
            load_count_nxt = '0;
            load_ovf_nxt   = 1'b0;
          end else if (sending_r) begin
            status_c       = evst_pkg::ST_BUSY;
            load_count_nxt = '0;
            load_ovf_nxt   = 1'b0;
          end else begin
            if (load_count_r < MAX_CNT) begin
              mem_we         = 1'b1;
              load_count_nxt = cnt_inc[CW-1:0];
              if (load_count_r == '0) begin
                first_byte_nxt = data_r;
              end
            end else begin
              ovf_c        = 1'b1;
              load_ovf_nxt = 1'b1;
            end
            if (!last_r) begin
              status_c = evst_pkg::ST_STORED;
            end else if (ovf_c) begin
              status_c       = evst_pkg::ST_TOO_LONG;
              load_count_nxt = '0;
              load_ovf_nxt   = 1'b0;
            end else begin
              // frame complete: first byte goes out now
              frame_size_nxt = load_count_nxt;
              send_pos_nxt   = '0;
              sending_nxt    = 1'b1;
              load_count_nxt = '0;
              load_ovf_nxt   = 1'b0;
              txv_c          = 1'b1;
              txb_c          = (load_count_r == '0) ? data_r : first_byte_r;
              expected_nxt   = txb_c;
              awaiting_nxt   = 1'b1;
              ticks_nxt      = echo_timeout;
            end
          end
        end
        evst_pkg::ACT_ECHO: begin
          if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            if (!faulted_r) begin
              if (data_r != expected_r) begin
                drop_nxt       = 1'b1;
                sending_nxt    = 1'b0;
                frame_size_nxt = '0;
                send_pos_nxt   = '0;
              end else if (pos_inc < {1'b0, frame_size_r}) begin
                send_pos_nxt = pos_inc[CW-1:0];
                txv_c        = 1'b1;
                txb_c        = next_byte;
                expected_nxt = next_byte;
                awaiting_nxt = 1'b1;
                ticks_nxt    = echo_timeout;
              end else begin
                sending_nxt    = 1'b0;
                frame_size_nxt = '0;
                send_pos_nxt   = '0;
              end
            end
          end
        end
        evst_pkg::ACT_TICK: begin
          if (!faulted_r && awaiting_r) begin
            if (ticks_r <= 16'd1) begin
              ticks_nxt      = '0;
              faulted_nxt    = 1'b1;
              sending_nxt    = 1'b0;
              frame_size_nxt = '0;
              send_pos_nxt   = '0;
              awaiting_nxt   = 1'b0;
            end else begin
              ticks_nxt = ticks_r - 16'd1;
            end
          end
        end
        evst_pkg::ACT_CONSUME: begin
          seen_c   = drop_r;
          drop_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      load_ovf_r   <= 1'b0;
      frame_size_r <= '0;
      send_pos_r   <= '0;
      expected_r   <= '0;
      awaiting_r   <= 1'b0;
      sending_r    <= 1'b0;
      faulted_r    <= 1'b0;
      drop_r       <= 1'b0;
      ticks_r      <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      load_ovf_r   <= load_ovf_nxt;
      frame_size_r <= frame_size_nxt;
      send_pos_r   <= send_pos_nxt;
      expected_r   <= expected_nxt;
      awaiting_r   <= awaiting_nxt;
      sending_r    <= sending_nxt;
      faulted_r    <= faulted_nxt;
      drop_r       <= drop_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_byte_r <= first_byte_nxt;
  end

  // frame store, read one position ahead of the sender
  assign rd_pos    = {1'b0, send_pos_nxt} + {{CW{1'b0}}, 1'b1};
  assign mem_raddr = rd_pos[AW-1:0];

  evst_ram #(
    .WIDTH (evst_pkg::DATA_W),
    .DEPTH (MAX_FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (data_r),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  // same-address write bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= mem_we && (mem_waddr == mem_raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= data_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v_r) begin
      status_r <= status_c;
      txv_r    <= txv_c;
      txb_r    <= txb_c;
      busy_r   <= sending_nxt;
      fault_r  <= faulted_nxt;
      seen_r   <= seen_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_tx_valid   = txv_r;
  assign out_tx_byte    = txb_r;
  assign out_busy_flag  = busy_r;
  assign out_fault_flag = fault_r;
  assign out_drop_seen  = seen_r;

endmodule

>>> rtl/core/echo_verified_serial_transmitter_unit.sv
// top level of the echo-verified serial transmitter
//
// Usage: each command beat (load byte, echo byte, tick, consume drop event)
// is presented on in_action, in_data_byte and in_last_byte with start high.
// busy stays low, so a beat is taken at every edge where start is high and
// one beat per cycle is sustained.
// Every beat yields exactly one result, shown on the out_ ports for one cycle
// with out_valid high, after the beat has passed the input register and then
// the state update feeding the result register.
// The frame store is a 64-entry ram read one position ahead of the sender,
// so the result of a matching echo already carries the next byte.
// The echo timeout register sits at byte address 0 of the apb port; write it
// only while no beat is in flight. pready is always high.
// Reset (synchronous, rst_n low) clears all frame state, the fault and the
// drop event and sets the timeout to 10 ticks; the store contents are kept.
// The receiver cannot stall: each result is taken in the cycle it appears.
module echo_verified_serial_transmitter_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_busy_flag,
  output logic        out_fault_flag,
  output logic        out_drop_seen,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [evst_pkg::TICK_W-1:0] echo_timeout;
  logic                        take;

  // every beat is taken
  assign busy = 1'b0;
  assign take = start && !busy;

  // configuration registers
  evst_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .echo_timeout (echo_timeout)
  );

  // frame engine
  evst_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_take        (take),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .echo_timeout   (echo_timeout),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_tx_valid   (out_tx_valid),
    .out_tx_byte    (out_tx_byte),
    .out_busy_flag  (out_busy_flag),
    .out_fault_flag (out_fault_flag),
    .out_drop_seen  (out_drop_seen)
  );

  // every taken beat is followed by its result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##2 out_valid)
    else $error("result strobe missing two cycles after a beat");

  // a transmitted byte always belongs to a frame in progress
  a_tx_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_busy_flag)
    else $error("byte transmitted with no frame in progress");

  // a fault abandons the frame
  a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_flag |-> !out_busy_flag && !out_tx_valid)
    else $error("frame still active while faulted");

endmodule

>>> bench/echo_verified_serial_transmitter_unit_tb.sv
// testbench for the echo-verified serial transmitter: directed and random beats, predicted results
`timescale 1ns / 100ps

module echo_verified_serial_transmitter_unit_tb;

  localparam int unsigned FRAME_DEPTH = 64;

  typedef struct packed {
    evst_pkg::status_t status;
    logic              tx_valid;
    logic [7:0]        tx_byte;
    logic              busy_flag;
    logic              fault_flag;
    logic              drop_seen;
  } beat_result_t;

  typedef struct {
    evst_pkg::action_t act;
    logic [7:0]        data;
    logic              last;
    logic              typed;
    beat_result_t      res;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = evst_pkg::ACT_CONSUME;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_busy_flag;
  logic        out_fault_flag;
  logic        out_drop_seen;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  echo_verified_serial_transmitter_unit #(
    .MAX_FRAME_BYTES(FRAME_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_tx_valid(out_tx_valid),
    .out_tx_byte(out_tx_byte),
    .out_busy_flag(out_busy_flag),
    .out_fault_flag(out_fault_flag),
    .out_drop_seen(out_drop_seen),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // transmitter state as predicted
  logic [7:0]                  frame_mem [FRAME_DEPTH];
  logic [6:0]                  fill_count = '0;
  logic                        fill_overflow = 1'b0;
  logic [6:0]                  tx_length = '0;
  logic [6:0]                  send_pos = '0;
  logic [7:0]                  echo_byte = '0;
  logic                        echo_wait = 1'b0;
  logic                        tx_active = 1'b0;
  logic                        fault_latched = 1'b0;
  logic                        drop_flag = 1'b0;
  logic [evst_pkg::TICK_W-1:0] ticks_remaining = '0;
  logic [evst_pkg::TICK_W-1:0] echo_timeout = evst_pkg::TIMEOUT_RESET;

  beat_result_t awaited_results[$];
  int unsigned  beats_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  idle_pct = 0;
  logic         fault_allowed = 1'b0;

  // directed beats: a short frame, busy refusal, echo match and mismatch, drop event
  dir_row_t dir_rows [0:16] = '{
    '{evst_pkg::ACT_CONSUME, 8'h00, 1'b0, 1'b1,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_ECHO, 8'hA5, 1'b1, 1'b1,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_TICK, 8'h00, 1'b0, 1'b1,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'h00, 1'b0, 1'b1,
      '{evst_pkg::ST_STORED, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'hFF, 1'b1, 1'b1,
      '{evst_pkg::ST_OK, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'h11, 1'b1, 1'b1,
      '{evst_pkg::ST_BUSY, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0}},
    '{evst_pkg::ACT_ECHO, 8'h00, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_TICK, 8'hFF, 1'b1, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_ECHO, 8'hFF, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'h3C, 1'b1, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_ECHO, 8'hC3, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_CONSUME, 8'hFF, 1'b1, 1'b1,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1}},
    '{evst_pkg::ACT_CONSUME, 8'h00, 1'b0, 1'b1,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'h7F, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_CONSUME, 8'h55, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_LOAD, 8'h80, 1'b1, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}},
    '{evst_pkg::ACT_ECHO, 8'h7F, 1'b0, 1'b0,
      '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}}
  };

  // put the byte at the send position on the line and arm the echo timer
  function automatic logic [7:0] launch_byte();
    echo_byte = frame_mem[send_pos[5:0]];
    echo_wait = 1'b1;
    ticks_remaining = echo_timeout;
    return echo_byte;
  endfunction

  function automatic void stop_sending();
    tx_active = 1'b0;
    tx_length = '0;
    send_pos = '0;
    echo_wait = 1'b0;
  endfunction

  // one beat through the predicted transmitter
  function automatic beat_result_t step_transmitter(evst_pkg::action_t act, logic [7:0] d,
                                                    logic l);
    beat_result_t r;
    r = '{evst_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
    case (act)
      evst_pkg::ACT_LOAD: begin
        if (fault_latched) begin
          r.status = evst_pkg::ST_FAULT;
          fill_count = '0;
          fill_overflow = 1'b0;
        end else if (tx_active) begin
          r.status = evst_pkg::ST_BUSY;
          fill_count = '0;
          fill_overflow = 1'b0;
        end else begin
          if (fill_count < FRAME_DEPTH) begin
            frame_mem[fill_count[5:0]] = d;
            fill_count = fill_count + 7'd1;
          end else begin
            fill_overflow = 1'b1;
          end
          if (!l) begin
            r.status = evst_pkg::ST_STORED;
          end else if (fill_overflow) begin
            r.status = evst_pkg::ST_TOO_LONG;
            fill_count = '0;
            fill_overflow = 1'b0;
          end else begin
            tx_length = fill_count;
            send_pos = '0;
            tx_active = 1'b1;
            fill_count = '0;
            fill_overflow = 1'b0;
            r.tx_valid = 1'b1;
            r.tx_byte = launch_byte();
          end
        end
      end
      evst_pkg::ACT_ECHO: begin
        if (echo_wait) begin
          echo_wait = 1'b0;
          if (!fault_latched) begin
            if (d != echo_byte) begin
              drop_flag = 1'b1;
              stop_sending();
            end else begin
              send_pos = send_pos + 7'd1;
              if (send_pos < tx_length) begin
                r.tx_valid = 1'b1;
                r.tx_byte = launch_byte();
              end else begin
                stop_sending();
              end
            end
          end
        end
      end
      evst_pkg::ACT_TICK: begin
        if (!fault_latched && echo_wait) begin
          if (ticks_remaining <= 1) begin
            ticks_remaining = '0;
            fault_latched = 1'b1;
            stop_sending();
          end else begin
            ticks_remaining = ticks_remaining - 1'b1;
          end
        end
      end
      default: begin
        r.drop_seen = drop_flag;
        drop_flag = 1'b0;
      end
    endcase
    r.busy_flag = tx_active;
    r.fault_flag = fault_latched;
    return r;
  endfunction

  // drive one command beat, hold it until taken, then queue its result
  task automatic send_beat(input evst_pkg::action_t act, input logic [7:0] d, input logic l,
                           input logic typed, input beat_result_t typed_res);
    beat_result_t pred;
    start <= 1'b1;
    in_action <= act;
    in_data_byte <= d;
    in_last_byte <= l;
    do @(posedge clk); while (busy !== 1'b0);
    pred = step_transmitter(act, d, l);
    awaited_results.push_back(typed ? typed_res : pred);
    beats_sent++;
  endtask

  // random beat with sender gaps; ticks that would time out are held back unless allowed
  task automatic issue(input evst_pkg::action_t act, input logic [7:0] d, input logic l);
    evst_pkg::action_t a;
    a = act;
    if (a == evst_pkg::ACT_TICK && !fault_allowed && echo_wait && !fault_latched &&
        ticks_remaining <= 1)
      a = evst_pkg::ACT_CONSUME;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    send_beat(a, d, l, 1'b0, '0);
  endtask

  // let every outstanding result drain, then let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // apb write to the echo timeout register, only while idle
  task automatic write_timeout(input logic [evst_pkg::TICK_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * evst_pkg::REG_ECHO_TIMEOUT);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    echo_timeout = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // frame of random content and length, at times too long for the store, then echoes with some ticks and noise
  task automatic run_frame();
    int unsigned len;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(1, 4);
    else if (r < 88) len = $urandom_range(5, 16);
    else if (r < 93) len = $urandom_range(17, 63);
    else if (r < 97) len = FRAME_DEPTH;
    else len = $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 3);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4)
        issue(evst_pkg::action_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      issue(evst_pkg::ACT_LOAD, 8'($urandom), i == len - 1);
    end
    while (tx_active) begin
      r = $urandom_range(99);
      if (r < 15) issue(evst_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
      else if (r < 19) issue(evst_pkg::ACT_CONSUME, 8'($urandom), 1'($urandom));
      else if (r < 23) issue(evst_pkg::ACT_LOAD, 8'($urandom), 1'($urandom));
      else if (r < 27)
        issue(evst_pkg::ACT_ECHO, echo_byte ^ 8'($urandom_range(1, 255)), 1'($urandom));
      else issue(evst_pkg::ACT_ECHO, echo_byte, 1'($urandom));
    end
  endtask

  task automatic run_phase(input int unsigned pct, input int unsigned count, input logic fault_ok);
    int unsigned first;
    idle_pct = pct;
    fault_allowed = fault_ok;
    first = beats_sent;
    while (beats_sent - first < count) begin
      if ($urandom_range(99) < 80) run_frame();
      else issue(evst_pkg::action_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    end
  endtask

  // result checker: each strobed beat against the oldest prediction
  always @(posedge clk) begin : check_results
    beat_result_t got;
    beat_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = '{evst_pkg::status_t'(out_status), out_tx_valid, out_tx_byte, out_busy_flag,
              out_fault_flag, out_drop_seen};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: st=%0d txv=%0b txb=%02h busy=%0b fault=%0b drop=%0b",
                   got.status, got.tx_valid, got.tx_byte, got.busy_flag, got.fault_flag,
                   got.drop_seen);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.tx_valid !== want.tx_valid ||
            got.tx_byte !== want.tx_byte || got.busy_flag !== want.busy_flag ||
            got.fault_flag !== want.fault_flag || got.drop_seen !== want.drop_seen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp st=%0d txv=%0b txb=%02h busy=%0b fault=%0b drop=%0b",
                     want.status, want.tx_valid, want.tx_byte, want.busy_flag,
                     want.fault_flag, want.drop_seen);
          if (mismatches <= 10)
            $display("                 got st=%0d txv=%0b txb=%02h busy=%0b fault=%0b drop=%0b",
                     got.status, got.tx_valid, got.tx_byte, got.busy_flag, got.fault_flag,
                     got.drop_seen);
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats after reset, default timeout
    foreach (dir_rows[i])
      send_beat(dir_rows[i].act, dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].res);
    issue(evst_pkg::ACT_ECHO, echo_byte, 1'b0);
    drain();

    // random phases under several timeouts and sender gap rates
    write_timeout(16'hFFFF);
    run_phase(0, 220, 1'b0);
    drain();
    write_timeout(16'd1);
    run_phase(65, 220, 1'b0);
    drain();
    write_timeout(16'd3);
    run_phase(0, 200, 1'b0);
    drain();
    write_timeout(16'd200);
    run_phase(6, 220, 1'b0);
    drain();

    // zero timeout: first tick faults, then everything runs against the sticky fault
    write_timeout(16'd0);
    fault_allowed = 1'b1;
    idle_pct = 0;
    issue(evst_pkg::ACT_LOAD, 8'($urandom), 1'b1);
    issue(evst_pkg::ACT_TICK, 8'($urandom), 1'b0);
    run_phase(30, 60, 1'b1);
    drain();

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("echo_verified_serial_transmitter_unit test passed");
    end else begin
      $display("echo_verified_serial_transmitter_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("echo_verified_serial_transmitter_unit test failed");
    $finish;
  end

endmodule
